FILE: rtl/wupc_pkg.sv
// ----------------------------------------------------------------------------
// wupc_pkg
// shared types and constants for the warm-up point planner
// ----------------------------------------------------------------------------
`default_nettype none

package wupc_pkg;

	localparam int WIN_W          = 24;
	localparam int TEMP_W         = 13;
	localparam int SPEED_W        = 14;
	localparam int CFG_IDX_W      = 3;
	localparam int MS_PER_STEP    = 10000;
	localparam int EXTRUDER_COUNT_DEF = 2;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HEAT_A  = 3'd0,
		REG_COOL_A  = 3'd1,
		REG_ECOOL_A = 3'd2,
		REG_HEAT_B  = 3'd3,
		REG_COOL_B  = 3'd4,
		REG_ECOOL_B = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [SPEED_W-1:0] heat;
		logic [SPEED_W-1:0] cool;
		logic [SPEED_W-1:0] ecool;
	} spd_t;

	typedef struct packed {
		logic [WIN_W-1:0]  window_ms;
		logic              extruder_select;
		logic [TEMP_W-1:0] start_temp;
		logic [TEMP_W-1:0] standby_temp;
		logic [TEMP_W-1:0] end_temp;
		logic              printing;
	} in_t;

	typedef struct packed {
		logic [WIN_W-1:0]  total_window;
		logic [WIN_W-1:0]  heat_time_ms;
		logic [TEMP_W-1:0] lowest_temp;
		logic              speed_error;
		logic              out_of_window;
	} out_t;

endpackage

`default_nettype wire

FILE: rtl/wupc_div.sv
// ----------------------------------------------------------------------------
// wupc_div
// pipelined restoring divider, one quotient bit per stage, with sideband
// ----------------------------------------------------------------------------
`default_nettype none

module wupc_div #(
	parameter int DW = 27,
	parameter int VW = 15,
	parameter int SW = 8
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_vld,
	input  wire logic [DW-1:0] num,
	input  wire logic [VW-1:0] den,
	input  wire logic [SW-1:0] side,
	output logic               out_vld,
	output logic [DW-1:0]      quo,
	output logic [SW-1:0]      side_out
);

	logic          vld_s  [DW+1];
	logic [VW-1:0] rem_s  [DW+1];
	logic [DW-1:0] num_s  [DW+1];
	logic [VW-1:0] den_s  [DW+1];
	logic [SW-1:0] side_s [DW+1];

	// entry of the chain
	assign vld_s[0]  = in_vld;
	assign rem_s[0]  = '0;
	assign num_s[0]  = num;
	assign den_s[0]  = den;
	assign side_s[0] = side;

	for (genvar k = 0; k < DW; k++) begin : g_stage
		logic [VW:0] trial;
		logic [VW:0] diff;
		logic        ge;

		// shift in the next dividend bit and try the subtract
		always_comb begin
			trial = {rem_s[k], num_s[k][DW-1]};
			diff  = trial - {1'b0, den_s[k]};
			ge    = trial >= {1'b0, den_s[k]};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k+1]  <= ge ? diff[VW-1:0] : trial[VW-1:0];
			num_s[k+1]  <= {num_s[k][DW-2:0], ge};
			den_s[k+1]  <= den_s[k];
			side_s[k+1] <= side_s[k];
		end
	end

	assign out_vld  = vld_s[DW];
	assign quo      = num_s[DW];
	assign side_out = side_s[DW];

endmodule

`default_nettype wire

FILE: rtl/warm_up_point_after_cool_down.sv
// Throughput: one item per cycle; busy is never raised and results are never held.
// The depth is set by the two bit-per-stage dividers in series (27 and 39 stages)
// plus six single register stages; the drop by 10000 is a reciprocal multiply.
// Reset clears all valid bits and loads the default speed registers.
// ----------------------------------------------------------------------------
// warm_up_point_after_cool_down
// plans heating start and lowest temperature of a nozzle dip in a window
// ----------------------------------------------------------------------------
`default_nettype none

module warm_up_point_after_cool_down #(
	parameter int EXTRUDER_COUNT = wupc_pkg::EXTRUDER_COUNT_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	input  wire wupc_pkg::in_t                item,
	output logic                              done,
	output wupc_pkg::out_t                    result,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [wupc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [wupc_pkg::SPEED_W-1:0] cfg_data
);

	import wupc_pkg::*;

	localparam int NUM_W  = 27;            // 10000 * 13-bit difference
	localparam int DEN_W  = SPEED_W + 1;
	localparam int CPH_W  = SPEED_W + 2;
	localparam int LIM_W  = NUM_W + 1;
	localparam int P1_W   = NUM_W + CPH_W;
	localparam int P2_W   = WIN_W + DEN_W;
	localparam int PROD_W = WIN_W + SPEED_W;
	localparam int EXT_B  = (EXTRUDER_COUNT > 1) ? 1 : 0;
	localparam int LAT    = 6 + NUM_W + P2_W;

	// reciprocal of 10000, exact for dividends below 10000 * 2^TEMP_W
	localparam int                 RECIP_W   = 28;
	localparam int                 RQ_W      = NUM_W + RECIP_W;
	localparam int                 RECIP_SH  = 41;
	localparam logic [RECIP_W-1:0] RECIP_10K = 28'd219902326;
	localparam logic [PROD_W-1:0]  DROP_BIG  = PROD_W'(MS_PER_STEP * (1 << TEMP_W));

	typedef struct packed {
		logic [WIN_W-1:0]  win;
		logic [TEMP_W-1:0] te;
		logic [TEMP_W-1:0] mn;
		logic              lt;
		logic              err;
	} a_side_t;

	typedef struct packed {
		logic [TEMP_W-1:0]  tm;
		logic [SPEED_W-1:0] h;
		logic [DEN_W-1:0]   c;
	} b_side_t;

	typedef struct packed {
		logic [WIN_W-1:0]   win;
		logic [TEMP_W-1:0]  te;
		logic [TEMP_W-1:0]  tm;
		logic [TEMP_W-1:0]  mn;
		logic               err;
		logic               neg;
		logic               fit;
		logic [NUM_W-1:0]   hb;
		logic [LIM_W-1:0]   heat_fit;
		logic [SPEED_W-1:0] h;
	} c_side_t;

	typedef struct packed {
		logic [WIN_W-1:0]  win;
		logic [TEMP_W-1:0] te;
		logic [TEMP_W-1:0] tm;
		logic [TEMP_W-1:0] mn;
		logic              err;
		logic              neg;
		logic              fit;
		logic [LIM_W-1:0]  heat_fit;
		logic [LIM_W-1:0]  heatc;
	} d_side_t;

	// speed register file
	spd_t spd_q [EXTRUDER_COUNT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int e = 0; e < EXTRUDER_COUNT; e++) begin
				spd_q[e].heat  <= SPEED_W'(200);
				spd_q[e].cool  <= SPEED_W'(200);
				spd_q[e].ecool <= SPEED_W'(70);
			end
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_HEAT_A:  spd_q[0].heat  <= cfg_data;
				REG_COOL_A:  spd_q[0].cool  <= cfg_data;
				REG_ECOOL_A: spd_q[0].ecool <= cfg_data;
				REG_HEAT_B:  if (EXTRUDER_COUNT > 1) spd_q[EXT_B].heat  <= cfg_data;
				REG_COOL_B:  if (EXTRUDER_COUNT > 1) spd_q[EXT_B].cool  <= cfg_data;
				REG_ECOOL_B: if (EXTRUDER_COUNT > 1) spd_q[EXT_B].ecool <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	// stage 1: effective speeds and move numerators
	spd_t                      set;
	logic [SPEED_W-1:0]        ecool;
	logic signed [SPEED_W+1:0] h_full;
	logic [DEN_W-1:0]          c_full;
	logic                      lt, use_h;
	logic [TEMP_W-1:0]         outer, d_a, d_b;

	always_comb begin
		set = spd_q[0];
		if (EXTRUDER_COUNT > 1 && item.extruder_select) set = spd_q[EXT_B];
		ecool  = item.printing ? set.ecool : '0;
		h_full = $signed({2'b00, set.heat}) - $signed({2'b00, ecool});
		c_full = {1'b0, set.cool} + {1'b0, ecool};
		lt     = item.start_temp < item.end_temp;
		outer  = lt ? item.start_temp : item.end_temp;
		d_a    = lt ? item.end_temp - item.start_temp : item.start_temp - item.end_temp;
		use_h  = outer > item.standby_temp;
		d_b    = use_h ? outer - item.standby_temp : item.standby_temp - outer;
	end

	logic               vld_s1;
	logic [NUM_W-1:0]   num_a_s1, num_b_s1;
	logic [DEN_W-1:0]   den_a_s1, den_b_s1;
	a_side_t            a_in_s1;
	b_side_t            b_in_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		num_a_s1    <= NUM_W'(d_a) * NUM_W'(MS_PER_STEP);
		num_b_s1    <= NUM_W'(d_b) * NUM_W'(MS_PER_STEP);
		den_a_s1    <= lt ? {1'b0, h_full[SPEED_W-1:0]} : c_full;
		den_b_s1    <= use_h ? {1'b0, h_full[SPEED_W-1:0]} : c_full;
		a_in_s1.win <= item.window_ms;
		a_in_s1.te  <= item.end_temp;
		a_in_s1.mn  <= lt ? item.start_temp : item.end_temp;
		a_in_s1.lt  <= lt;
		a_in_s1.err <= (h_full <= 0) || (c_full == '0);
		b_in_s1.tm  <= item.standby_temp;
		b_in_s1.h   <= h_full[SPEED_W-1:0];
		b_in_s1.c   <= c_full;
	end

	// extra and dip times
	logic                      a_vld, b_vld;
	logic [NUM_W-1:0]          a_quo, b_quo;
	logic [$bits(a_side_t)-1:0] a_side_o;
	logic [$bits(b_side_t)-1:0] b_side_o;

	wupc_div #(.DW(NUM_W), .VW(DEN_W), .SW($bits(a_side_t))) u_div_a (
		.clk(clk), .arst_n(arst_n), .in_vld(vld_s1), .num(num_a_s1), .den(den_a_s1),
		.side(a_in_s1), .out_vld(a_vld), .quo(a_quo), .side_out(a_side_o)
	);

	wupc_div #(.DW(NUM_W), .VW(DEN_W), .SW($bits(b_side_t))) u_div_b (
		.clk(clk), .arst_n(arst_n), .in_vld(vld_s1), .num(num_b_s1), .den(den_b_s1),
		.side(b_in_s1), .out_vld(b_vld), .quo(b_quo), .side_out(b_side_o)
	);

	// stage 2: limited window and the products for the fit test
	a_side_t                 a_sd;
	b_side_t                 b_sd;
	logic signed [LIM_W-1:0] lim;
	logic [CPH_W-1:0]        cph;

	always_comb begin
		a_sd = a_side_t'(a_side_o);
		b_sd = b_side_t'(b_side_o);
		lim  = $signed({4'b0000, a_sd.win}) - $signed({1'b0, a_quo});
		cph  = CPH_W'(b_sd.c) + CPH_W'(b_sd.h);
	end

	logic              vld_s2;
	logic [P1_W-1:0]   p1_s2;
	logic [P2_W-1:0]   p2_s2;
	logic [CPH_W-1:0]  cph_s2;
	logic              neg_s2;
	logic [NUM_W-1:0]  extra_s2, t_s2;
	a_side_t           a_s2;
	b_side_t           b_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= a_vld & b_vld;
		end
	end

	always_ff @(posedge clk) begin
		p1_s2    <= P1_W'(b_quo) * P1_W'(cph);
		p2_s2    <= P2_W'(lim[WIN_W-1:0]) * P2_W'(b_sd.c);
		cph_s2   <= cph;
		neg_s2   <= lim[LIM_W-1];
		extra_s2 <= a_quo;
		t_s2     <= b_quo;
		a_s2     <= a_sd;
		b_s2     <= b_sd;
	end

	// fit test and heating split into the divider
	c_side_t          c_in;
	logic [NUM_W-1:0] hb;

	always_comb begin
		hb           = a_s2.lt ? extra_s2 : '0;
		c_in.win     = a_s2.win;
		c_in.te      = a_s2.te;
		c_in.tm      = b_s2.tm;
		c_in.mn      = a_s2.mn;
		c_in.err     = a_s2.err;
		c_in.neg     = neg_s2;
		c_in.fit     = p1_s2 < P1_W'(p2_s2);
		c_in.hb      = hb;
		c_in.heat_fit = LIM_W'(hb) + LIM_W'(t_s2);
		c_in.h       = b_s2.h;
	end

	logic                       c_vld;
	logic [P2_W-1:0]            c_quo;
	logic [$bits(c_side_t)-1:0] c_side_o;

	wupc_div #(.DW(P2_W), .VW(CPH_W), .SW($bits(c_side_t))) u_div_c (
		.clk(clk), .arst_n(arst_n), .in_vld(vld_s2), .num(p2_s2), .den(cph_s2),
		.side(c_in), .out_vld(c_vld), .quo(c_quo), .side_out(c_side_o)
	);

	// stage 3: heating time of the split case
	c_side_t          c_sd;
	logic             vld_s3;
	logic             vld_s4;
	logic             vld_s5;
	c_side_t          c_s3;
	logic [LIM_W-1:0] heatc_s3;

	assign c_sd = c_side_t'(c_side_o);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s3 <= c_vld;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		c_s3     <= c_sd;
		heatc_s3 <= LIM_W'(c_sd.hb) + c_quo[LIM_W-1:0];
	end

	// stage 4: temperature drop product
	logic [PROD_W-1:0] prod_s4;
	d_side_t           d_s4;

	always_ff @(posedge clk) begin
		prod_s4       <= PROD_W'(heatc_s3[WIN_W-1:0]) * PROD_W'(c_s3.h);
		d_s4.win      <= c_s3.win;
		d_s4.te       <= c_s3.te;
		d_s4.tm       <= c_s3.tm;
		d_s4.mn       <= c_s3.mn;
		d_s4.err      <= c_s3.err;
		d_s4.neg      <= c_s3.neg;
		d_s4.fit      <= c_s3.fit;
		d_s4.heat_fit <= c_s3.heat_fit;
		d_s4.heatc    <= heatc_s3;
	end

	// stage 5: drop in tenths by reciprocal multiplication
	logic            big_s5;
	logic [RQ_W-1:0] rq_s5;
	d_side_t         d_s5;

	always_ff @(posedge clk) begin
		big_s5 <= prod_s4 >= DROP_BIG;
		rq_s5  <= RQ_W'(prod_s4[NUM_W-1:0]) * RQ_W'(RECIP_10K);
		d_s5   <= d_s4;
	end

	// stage 6: pick the case, clamp and saturate
	logic [TEMP_W:0]          drop;
	logic signed [TEMP_W+1:0] low_raw;
	logic [LIM_W-1:0]         heat_sel;
	out_t                     res;

	always_comb begin
		drop     = rq_s5[RECIP_SH +: TEMP_W+1];
		low_raw  = $signed({2'b00, d_s5.te}) - $signed({1'b0, drop});
		heat_sel = d_s5.fit ? d_s5.heat_fit : d_s5.heatc;
		res.total_window  = d_s5.win;
		res.speed_error   = d_s5.err;
		res.heat_time_ms  = '0;
		res.lowest_temp   = d_s5.mn;
		res.out_of_window = 1'b0;
		if (!d_s5.err && !d_s5.neg) begin
			res.out_of_window = heat_sel > LIM_W'(d_s5.win);
			res.heat_time_ms  = (heat_sel > LIM_W'({WIN_W{1'b1}})) ? {WIN_W{1'b1}}
				: heat_sel[WIN_W-1:0];
			if (d_s5.fit) begin
				res.lowest_temp = d_s5.tm;
			end else if (big_s5 || low_raw < $signed({2'b00, d_s5.tm})) begin
				res.lowest_temp = d_s5.tm;
			end else begin
				res.lowest_temp = low_raw[TEMP_W-1:0];
			end
		end
	end

	logic done_s6;
	out_t res_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s6 <= 1'b0;
		end else begin
			done_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		res_s6 <= res;
	end

	assign done   = done_s6;
	assign result = res_s6;

	// the two time dividers run in lock step
	a_lockstep: assert property (@(posedge clk) disable iff (!arst_n) a_vld == b_vld)
		else $error("time dividers out of step");

	// every accepted beat comes out after the fixed latency
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("result strobe missing after accepted beat");

	// a speed fault gives no heating time and no window warning
	a_fault: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.speed_error) |-> (result.heat_time_ms == '0 && !result.out_of_window))
		else $error("speed fault with heating time");

endmodule

`default_nettype wire
